// ===== rtl/core/slfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_AW   = 2;

    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [LEN_W:0]    MIN_FRAME = 17'd10;
    localparam logic [LEN_W:0]    HDR_BYTES = 17'd4;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;
    localparam logic [BYTE_W-1:0] COMMAND_RST     = 8'h61;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_COMMAND     = 2'd2
    } t_cfg_index;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE      = 3'd0,
        ST_GOOD      = 3'd1,
        ST_SHORT     = 3'd2,
        ST_BAD_CMD   = 3'd3,
        ST_BAD_SUM   = 3'd4,
        ST_BAD_CRC   = 3'd5,
        ST_TOO_LARGE = 3'd6
    } t_frame_status;

    // reflected CRC, one byte per call
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/sync_length_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_core
// Hunts two sync bytes, reads a little-endian length, checks length, command, sum and CRC.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one received byte per beat on s_axis tdata.
//  - Master stream: one result beat per input beat. tdata carries the echoed
//    byte, its frame position and the frame status; tuser flags whether the
//    byte was taken into a frame. Status is non-zero only on the byte that
//    ends a frame.
//  - Config port: write enable, index and byte; sync pair and command code.
//    Write only while both streams are quiet.
//  - Pipeline: input register, then result register. Throughput: one byte
//    per cycle while the master does not stall; the frame state, byte-wide
//    CRC and sum are all updated in the single step between the two
//    registers.
//  - Reset: both stages empty, receiver hunting the first sync byte, config
//    registers at their default values.
//  - Stall: while the result register is held by a stalled master, the input
//    register holds and tready drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_core
    import slfr_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [BYTE_W-1:0]   i_cfg_wdata,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [7:0]          i_s_axis_tdata,   // [7:0] data_byte
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [23:0]         o_m_axis_tdata,   // [7:0] echo_byte,
                                                  // [15:8] frame_position,
                                                  // [18:16] frame_status
    output logic                o_m_axis_tuser    // [0] in_frame
);

    localparam int unsigned POS_W = $clog2(BUFFER_BYTES);
    localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W+1)'(BUFFER_BYTES - 4);

    localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC2 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_L = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_H = POS_W'(3);
    localparam logic [POS_W-1:0] POS_CMD   = POS_W'(4);

    // config
    logic [BYTE_W-1:0] r_sync_first, r_sync_second, r_command;

    // stages
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic [BYTE_W-1:0] r_out_pos;
    logic              r_out_inf;
    t_frame_status     r_out_status;

    // frame state
    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [LEN_W-1:0]  r_len,  n_len;
    logic [BYTE_W-1:0] r_sum,  n_sum;
    logic [CRC_W-1:0]  r_crc,  n_crc;
    logic              r_cmd,  n_cmd;

    logic              out_free, advance;
    logic              inf;
    t_frame_status     status;
    logic [LEN_W:0]    len_x, pos_x, pos_len_x;
    logic [BYTE_W-1:0] sum_abs;
    logic [CRC_W-1:0]  crc_abs;
    logic              cmd_now;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    assign len_x     = {1'b0, r_len};
    assign pos_x     = (LEN_W+1)'(r_pos);
    assign pos_len_x = pos_x + (LEN_W+1)'(1);
    assign sum_abs   = r_sum + r_in_byte;
    assign crc_abs   = crc16_byte(r_crc, r_in_byte);
    assign cmd_now   = (r_pos == POS_CMD) ? (r_in_byte == r_command) : r_cmd;

    always_comb begin
        n_pos  = r_pos;
        n_len  = r_len;
        n_sum  = r_sum;
        n_crc  = r_crc;
        n_cmd  = r_cmd;
        inf    = 1'b1;
        status = ST_NONE;
        priority if (r_pos == POS_HUNT) begin
            if (r_in_byte == r_sync_first) begin
                n_len = '0;
                n_cmd = 1'b0;
                n_sum = r_in_byte;
                n_crc = crc16_byte(CRC_INIT, r_in_byte);
                n_pos = POS_SYNC2;
            end else begin
                inf = 1'b0;
            end
        end else if (r_pos == POS_SYNC2) begin
            if (r_in_byte == r_sync_second) begin
                n_sum = sum_abs;
                n_crc = crc_abs;
                n_pos = POS_LEN_L;
            end else begin
                inf   = 1'b0;
                n_pos = POS_HUNT;
            end
        end else if (r_pos == POS_LEN_L) begin
            n_len = {8'h00, r_in_byte};
            n_sum = sum_abs;
            n_crc = crc_abs;
            n_pos = POS_LEN_H;
        end else if (r_pos == POS_LEN_H) begin
            n_len = {r_in_byte, r_len[7:0]};
            n_sum = sum_abs;
            n_crc = crc_abs;
            n_pos = POS_CMD;
        end else begin
            n_cmd = cmd_now;
            priority if (len_x >= LEN_LIMIT) begin
                status = ST_TOO_LARGE;
                n_pos  = POS_HUNT;
            end else if (r_len == '0) begin
                status = ST_SHORT;
                n_pos  = POS_HUNT;
            end else if (pos_len_x == len_x + HDR_BYTES) begin
                priority if (len_x + HDR_BYTES < MIN_FRAME) begin
                    status = ST_SHORT;
                end else if (!cmd_now) begin
                    status = ST_BAD_CMD;
                end else if (r_sum != r_in_byte) begin
                    status = ST_BAD_SUM;
                end else if (r_crc != '0) begin
                    status = ST_BAD_CRC;
                end else begin
                    status = ST_GOOD;
                end
                n_pos = POS_HUNT;
            end else begin
                n_sum = sum_abs;
                n_crc = crc_abs;
                n_pos = pos_len_x[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_command     <= COMMAND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                CFG_COMMAND:     r_command     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= POS_HUNT;
            r_len       <= '0;
            r_sum       <= '0;
            r_crc       <= CRC_INIT;
            r_cmd       <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_pos <= n_pos;
                r_len <= n_len;
                r_sum <= n_sum;
                r_crc <= n_crc;
                r_cmd <= n_cmd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (advance) begin
            r_out_byte   <= r_in_byte;
            r_out_pos    <= inf ? pos_x[BYTE_W-1:0] : '0;
            r_out_inf    <= inf;
            r_out_status <= status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_status, r_out_pos, r_out_byte};
    assign o_m_axis_tuser  = r_out_inf;

endmodule

// ===== rtl/core/slfr_checker.sv =====
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks on the frame receiver's result stream.
// ----------------------------------------------------------------------------
module slfr_checker
    import slfr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed under stall");

    // bytes outside a frame carry no position and no status
    a_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata[15:8] == 8'd0 && o_m_axis_tdata[18:16] == ST_NONE)
        else $error("status or position on a byte outside a frame");

    // a frame never ends below the command position
    a_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[18:16] != ST_NONE |->
            o_m_axis_tdata[15:8] >= 8'd4 || o_m_axis_tdata[15:8] == 8'd0)
        else $error("frame ended inside its header");

    // status code range and padding
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[18:16] != 3'd7 && o_m_axis_tdata[23:19] == 5'd0)
        else $error("invalid status code or padding");

    // nothing comes out in the cycle after reset
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result beat straight after reset");

endmodule

bind sync_length_frame_receiver_core slfr_checker u_slfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
